>>> sv/fnpdp_pkg.sv
// Shared constants, widths and codes of the fractional-N divider planner.
package fnpdp_pkg;

    // Widths of the shared long divider.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;

    // Frequency plan limits, hertz.
    localparam logic [40:0] VCO_TOP     = 41'd6000000000;
    localparam logic [32:0] RF_LOW      = 33'd23437500;
    localparam logic [28:0] LD_FAST_PFD = 29'd32000000;

    // Feedback divider limits.
    localparam logic [16:0] N_INT_MIN  = 17'd16;
    localparam logic [16:0] N_FRAC_MIN = 17'd19;
    localparam logic [16:0] N_FRAC_MAX = 17'd4091;

    // Largest modulus that the mediant walk may reach.
    localparam logic [12:0] WALK_DEN_LIMIT = 13'd4095;

    // Configuration register indexes.
    localparam logic [2:0] CFG_REF_FREQ       = 3'd0;
    localparam logic [2:0] CFG_R_DIVIDER      = 3'd1;
    localparam logic [2:0] CFG_REF_DOUBLE     = 3'd2;
    localparam logic [2:0] CFG_REF_HALF       = 3'd3;
    localparam logic [2:0] CFG_PFD_FRAC_LIMIT = 3'd4;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RF_RANGE  = 3'd1,
        ST_ZERO_PFD  = 3'd2,
        ST_MOD_RANGE = 3'd3,
        ST_INT_N     = 3'd4,
        ST_FRAC_N    = 3'd5,
        ST_PFD_HIGH  = 3'd6
    } t_status;

endpackage

>>> sv/fnpdp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module fnpdp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fnpdp_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [fnpdp_pkg::DIV_DEN_W-1:0] i_den,
    output logic                            o_done,
    output logic [fnpdp_pkg::DIV_NUM_W-1:0] o_quo
);
    localparam int NW = fnpdp_pkg::DIV_NUM_W;
    localparam int DW = fnpdp_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {r_rem, r_quo[NW-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                // The dividend shifts out at the top as quotient bits enter below.
                r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_quo <= {r_quo[NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> sv/frac_n_pll_divider_planner.sv
// Top level of the fractional-N divider planner: sequencer, shared multiplier and divider.
//
// One target frequency item is taken when start is high and busy is low; busy then stays
// high until the plan is out. An out-of-range target or a zero phase detector frequency
// gives its result straight from the check state, with no division. Any other plan needs
// four long divisions plus single-state steps, a pass through S_W0, S_W1 and S_W2 for
// each step of the mediant walk, the steps S_F1 to S_F6 when the walk stops at the modulus
// bound, and one more VCO division when a best fraction of 1/1 makes it run again. The
// walk can run up to 4094 steps, and an exact integer plan also walks to the bound. The
// run time is set by the single registered 34x30 multiplier, used twice per walk step,
// and by the one bit-per-cycle divider. The result item is shown for exactly one cycle
// with o_valid high; the receiver cannot hold it off, so it must take it in that cycle.
// Configuration registers may be written only while busy is low and no result is pending.
module frac_n_pll_divider_planner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [27:0]        i_cfg_data,
    input  logic [32:0]        i_target_freq,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [15:0]        o_int_n,
    output logic [11:0]        o_frac_num,
    output logic [11:0]        o_frac_mod,
    output logic [2:0]         o_div_select,
    output logic               o_int_mode,
    output logic               o_lock_speed_fast,
    output logic [32:0]        o_actual_freq,
    output logic signed [31:0] o_freq_error,
    output logic [31:0]        o_reg0_word
);
    // One-hot sequencer states.
    typedef enum logic [24:0] {
        S_IDLE = 25'h0000001,
        S_CHK  = 25'h0000002,
        S_PFD  = 25'h0000004,
        S_N    = 25'h0000008,
        S_NDIV = 25'h0000010,
        S_FV   = 25'h0000020,
        S_FVD  = 25'h0000040,
        S_FVW  = 25'h0000080,
        S_A    = 25'h0000100,
        S_AC   = 25'h0000200,
        S_W0   = 25'h0000400,
        S_W1   = 25'h0000800,
        S_W2   = 25'h0001000,
        S_F1   = 25'h0002000,
        S_F2   = 25'h0004000,
        S_F3   = 25'h0008000,
        S_F4   = 25'h0010000,
        S_F5   = 25'h0020000,
        S_F6   = 25'h0040000,
        S_POST = 25'h0080000,
        S_FR   = 25'h0100000,
        S_FR2  = 25'h0200000,
        S_FR3  = 25'h0400000,
        S_FRW  = 25'h0800000,
        S_FIN  = 25'h1000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [27:0] r_ref_freq;
    logic [9:0]  r_r_divider;
    logic        r_ref_double;
    logic        r_ref_half;
    logic [27:0] r_pfd_frac_limit;

    // Working registers of one item.
    logic [32:0] r_freq;
    logic [32:0] r_target;
    logic [2:0]  r_sel;
    logic [28:0] r_pfd;
    logic        r_fast;
    logic [16:0] r_n;
    logic [33:0] r_fvco;
    logic [43:0] r_a;
    logic        r_redo;
    logic [11:0] r_ln, r_ld, r_un, r_ud;
    logic [11:0] r_frac, r_mod;
    logic [63:0] r_lhs;
    logic [23:0] r_t;
    logic [24:0] r_t2;
    logic [63:0] r_prod;

    // Result registers.
    logic        r_valid;
    logic [2:0]  r_status;
    logic [15:0] r_int_n;
    logic [11:0] r_frac_num;
    logic [11:0] r_frac_mod;
    logic [2:0]  r_div_select;
    logic        r_int_mode;
    logic        r_fast_out;
    logic [32:0] r_actual;
    logic [31:0] r_err;
    logic [31:0] r_reg0;

    // Shared multiplier and divider ports.
    logic [33:0]                       mul_a;
    logic [29:0]                       mul_b;
    logic                              div_start;
    logic [fnpdp_pkg::DIV_NUM_W-1:0]   div_num;
    logic [fnpdp_pkg::DIV_DEN_W-1:0]   div_den;
    logic                              div_done;
    logic [fnpdp_pkg::DIV_NUM_W-1:0]   div_quo;

    // Reference after doubler and halver, and the zero-PFD test.
    logic [28:0] ref2;
    logic [28:0] intref;
    logic [10:0] rdiv_scaled;
    logic        zero_pfd;
    logic        rf_bad;
    logic [33:0] freq_p1;
    logic [6:0]  fits;
    logic [2:0]  sel;
    logic [39:0] target_full;
    logic [12:0] mn, md;
    logic [33:0] fvco_fin;
    logic [33:0] actual_full;
    logic        fin_int;
    logic [2:0]  fin_status;

    assign ref2        = {1'b0, r_ref_freq} << r_ref_double;
    assign intref      = ref2 >> r_ref_half;
    assign rdiv_scaled = {1'b0, r_r_divider} << r_ref_half;
    // (ref / R) halved is zero exactly when ref is below R, or below 2R when halving.
    assign zero_pfd = (r_r_divider == 10'd0) || ({1'b0, r_ref_freq} < {18'd0, rdiv_scaled})
                      || (intref == 29'd0);
    assign rf_bad   = (r_freq > fnpdp_pkg::VCO_TOP[32:0]) || (r_freq < fnpdp_pkg::RF_LOW);

    // The output divider 2^(s+1) is allowed when 2^(s+1) * (f + 1) stays within the VCO top,
    // which is the same test as comparing against the truncated quotient.
    assign freq_p1 = {1'b0, r_freq} + 34'd1;
    always_comb begin
        for (int s = 0; s < 7; s++) begin
            fits[s] = (({7'd0, freq_p1} << (s + 1)) <= fnpdp_pkg::VCO_TOP);
        end
    end
    assign sel         = 3'($countones(fits));
    assign target_full = {7'd0, r_freq} << sel;

    // Mediant of the current bounds.
    assign mn = {1'b0, r_ln} + {1'b0, r_un};
    assign md = {1'b0, r_ld} + {1'b0, r_ud};

    assign fvco_fin    = r_fvco;
    assign actual_full = fvco_fin >> r_sel;
    assign fin_int     = (r_frac == 12'd0);

    always_comb begin
        if (fin_int) begin
            if ((r_n < fnpdp_pkg::N_INT_MIN) || r_n[16]) begin
                fin_status = fnpdp_pkg::ST_INT_N;
            end else begin
                fin_status = fnpdp_pkg::ST_OK;
            end
        end else if ((r_n < fnpdp_pkg::N_FRAC_MIN) || (r_n > fnpdp_pkg::N_FRAC_MAX)) begin
            fin_status = fnpdp_pkg::ST_FRAC_N;
        end else if (r_pfd > {1'b0, r_pfd_frac_limit}) begin
            fin_status = fnpdp_pkg::ST_PFD_HIGH;
        end else begin
            fin_status = fnpdp_pkg::ST_OK;
        end
    end

    // Operand selection for the shared units. The product is registered, so the state
    // after the one that picks the operands reads it.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_CHK: begin
                div_start = !zero_pfd && !rf_bad;
                div_num   = {19'd0, intref};
                div_den   = {22'd0, r_r_divider};
            end
            S_PFD: begin
                mul_a = {1'b0, r_target};
                mul_b = {20'd0, r_r_divider};
            end
            S_N: begin
                div_start = 1'b1;
                div_num   = r_prod[47:0];
                div_den   = {3'd0, intref};
            end
            S_FV: begin
                mul_a = {5'd0, intref};
                mul_b = {13'd0, r_n};
            end
            S_FVD: begin
                div_start = 1'b1;
                div_num   = r_prod[47:0];
                div_den   = {22'd0, r_r_divider};
            end
            S_A: begin
                mul_a = {1'b0, r_target} - r_fvco;
                mul_b = {20'd0, r_r_divider};
            end
            S_W0: begin
                mul_a = {21'd0, mn};
                mul_b = {1'b0, intref};
            end
            S_W1: begin
                mul_a = {5'd0, r_a[28:0]};
                mul_b = {17'd0, md};
            end
            S_F1: begin
                mul_a = {22'd0, r_ld};
                mul_b = {18'd0, r_ud};
            end
            S_F2: begin
                mul_a = {22'd0, r_un};
                mul_b = {18'd0, r_ld};
            end
            S_F3: begin
                mul_a = {22'd0, r_ln};
                mul_b = {18'd0, r_ud};
            end
            S_F4: begin
                mul_a = {4'd0, r_a[28:0], 1'b0};
                mul_b = {6'd0, r_t};
            end
            S_F5: begin
                mul_a = {9'd0, r_t2};
                mul_b = {1'b0, intref};
            end
            S_FR: begin
                mul_a = {5'd0, intref};
                mul_b = {18'd0, r_frac};
            end
            S_FR2: begin
                mul_a = {24'd0, r_r_divider};
                mul_b = {18'd0, r_mod};
            end
            S_FR3: begin
                div_start = 1'b1;
                div_num   = r_lhs[47:0];
                div_den   = r_prod[31:0];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    fnpdp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq       <= 28'd50000000;
            r_r_divider      <= 10'd1;
            r_ref_double     <= 1'b0;
            r_ref_half       <= 1'b0;
            r_pfd_frac_limit <= 28'd50000000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fnpdp_pkg::CFG_REF_FREQ:       r_ref_freq       <= i_cfg_data;
                fnpdp_pkg::CFG_R_DIVIDER:      r_r_divider      <= i_cfg_data[9:0];
                fnpdp_pkg::CFG_REF_DOUBLE:     r_ref_double     <= i_cfg_data[0];
                fnpdp_pkg::CFG_REF_HALF:       r_ref_half       <= i_cfg_data[0];
                fnpdp_pkg::CFG_PFD_FRAC_LIMIT: r_pfd_frac_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_freq  <= i_target_freq;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_sel    <= sel;
                    r_target <= target_full[32:0];
                    if (zero_pfd || rf_bad) begin
                        // Early errors carry nothing but the status.
                        r_status     <= zero_pfd ? fnpdp_pkg::ST_ZERO_PFD
                                                 : fnpdp_pkg::ST_RF_RANGE;
                        r_int_n      <= '0;
                        r_frac_num   <= '0;
                        r_frac_mod   <= '0;
                        r_div_select <= '0;
                        r_int_mode   <= 1'b0;
                        r_fast_out   <= 1'b0;
                        r_actual     <= '0;
                        r_err        <= '0;
                        r_reg0       <= '0;
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_PFD;
                    end
                end
                S_PFD: begin
                    if (div_done) begin
                        r_pfd   <= div_quo[28:0];
                        r_fast  <= (div_quo[28:0] > fnpdp_pkg::LD_FAST_PFD);
                        r_state <= S_N;
                    end
                end
                S_N: begin
                    r_state <= S_NDIV;
                end
                S_NDIV: begin
                    if (div_done) begin
                        r_n     <= {1'b0, div_quo[15:0]};
                        r_redo  <= 1'b0;
                        r_state <= S_FV;
                    end
                end
                S_FV: begin
                    r_state <= S_FVD;
                end
                S_FVD: begin
                    r_state <= S_FVW;
                end
                S_FVW: begin
                    if (div_done) begin
                        r_fvco  <= div_quo[33:0];
                        r_state <= r_redo ? S_FR : S_A;
                    end
                end
                S_A: begin
                    r_state <= S_AC;
                end
                S_AC: begin
                    r_a <= r_prod[43:0];
                    // A residual of one or more gives 1/1 at once.
                    if (r_prod >= {35'd0, intref}) begin
                        r_frac  <= 12'd1;
                        r_mod   <= 12'd1;
                        r_state <= S_POST;
                    end else begin
                        r_ln    <= 12'd0;
                        r_ld    <= 12'd1;
                        r_un    <= 12'd1;
                        r_ud    <= 12'd1;
                        r_state <= S_W0;
                    end
                end
                S_W0: begin
                    r_state <= (md > fnpdp_pkg::WALK_DEN_LIMIT) ? S_F1 : S_W1;
                end
                S_W1: begin
                    r_lhs   <= r_prod;
                    r_state <= S_W2;
                end
                S_W2: begin
                    if (r_lhs == r_prod) begin
                        r_frac  <= mn[11:0];
                        r_mod   <= md[11:0];
                        r_state <= S_POST;
                    end else begin
                        if (r_lhs < r_prod) begin
                            r_ln <= mn[11:0];
                            r_ld <= md[11:0];
                        end else begin
                            r_un <= mn[11:0];
                            r_ud <= md[11:0];
                        end
                        r_state <= S_W0;
                    end
                end
                S_F1: begin
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_t     <= r_prod[23:0];
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_t2    <= {1'b0, r_prod[23:0]};
                    r_state <= S_F4;
                end
                S_F4: begin
                    r_t2    <= r_t2 + {1'b0, r_prod[23:0]};
                    r_state <= S_F5;
                end
                S_F5: begin
                    r_lhs   <= r_prod;
                    r_state <= S_F6;
                end
                S_F6: begin
                    // Closer bound wins; a tie goes to the upper one.
                    if (r_lhs < r_prod) begin
                        r_frac <= r_ln;
                        r_mod  <= r_ld;
                    end else begin
                        r_frac <= r_un;
                        r_mod  <= r_ud;
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_state <= S_FR;
                    if (r_mod == 12'd1) begin
                        r_mod <= 12'd2;
                        if (r_frac == 12'd1) begin
                            // 1/1 folds into the integer part; redo the VCO product.
                            r_frac  <= 12'd0;
                            r_n     <= r_n + 17'd1;
                            r_redo  <= 1'b1;
                            r_state <= S_FV;
                        end
                    end
                end
                S_FR: begin
                    r_state <= S_FR2;
                end
                S_FR2: begin
                    r_lhs   <= r_prod;
                    r_state <= S_FR3;
                end
                S_FR3: begin
                    r_state <= S_FRW;
                end
                S_FRW: begin
                    if (div_done) begin
                        r_fvco  <= r_fvco + div_quo[33:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_status     <= fin_status;
                    r_int_n      <= r_n[15:0];
                    r_frac_num   <= r_frac;
                    r_frac_mod   <= r_mod;
                    r_div_select <= r_sel;
                    r_int_mode   <= fin_int;
                    r_fast_out   <= r_fast;
                    r_actual     <= actual_full[32:0];
                    r_err        <= r_freq[31:0] - actual_full[31:0];
                    r_reg0       <= (fin_status == fnpdp_pkg::ST_OK)
                                    ? {fin_int, r_n[15:0], r_frac, 3'd0} : 32'd0;
                    r_valid      <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_int_n           = r_int_n;
    assign o_frac_num        = r_frac_num;
    assign o_frac_mod        = r_frac_mod;
    assign o_div_select      = r_div_select;
    assign o_int_mode        = r_int_mode;
    assign o_lock_speed_fast = r_fast_out;
    assign o_actual_freq     = r_actual;
    assign o_freq_error      = $signed(r_err);
    assign o_reg0_word       = r_reg0;

    // A result is one cycle wide, since the sequencer returns to idle as it shows it.
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // An accepted item always makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // A result only ever follows work in progress.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result appeared without an item in work");

endmodule
